// ===== hdl/pin_check_with_lockout_macros.svh =====
// Assertion macros used by the pin checker top level.
`ifndef PIN_CHECK_WITH_LOCKOUT_MACROS_SVH
`define PIN_CHECK_WITH_LOCKOUT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define PCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PCL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pcl_pkg.sv =====
// Types, constants and the helper function of the pin checker.
`default_nettype none

package pcl_pkg;

    localparam int PIN_WIDTH   = 48;
    localparam int PIN_BYTES   = PIN_WIDTH / 8;
    localparam int PIN_DIGITS  = 6;
    localparam int USED_DIGITS = (PIN_DIGITS < PIN_BYTES) ? PIN_DIGITS : PIN_BYTES;

    localparam logic [PIN_WIDTH-1:0] USED_MASK =
        {PIN_WIDTH{1'b1}} >> (8 * (PIN_BYTES - USED_DIGITS));
    localparam logic [PIN_WIDTH-1:0] RESET_PIN = 48'h313233343536;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [3:0]  RESET_MAX_ATTEMPTS = 4'd5;
    localparam logic [31:0] RESET_LOCKOUT_MS   = 32'd300000;
    localparam logic [3:0]  COUNT_MAX          = 4'hF;

    typedef enum logic [1:0] {
        OP_VALIDATE = 2'd0,
        OP_CHANGE   = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LOCKED      = 3'd1,
        ST_BAD_FORMAT  = 3'd2,
        ST_WRONG_PIN   = 3'd3,
        ST_NEW_BAD     = 3'd4,
        ST_NEW_SAME    = 3'd5
    } status_t;

    typedef enum logic {
        REG_MAX_ATTEMPTS = 1'b0,
        REG_LOCKOUT_MS   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [PIN_WIDTH-1:0] pin;
        logic [3:0]           fail;
        logic                 locked;
        logic [31:0]          start;
    } pcl_state_t;

    typedef struct packed {
        logic       accepted;
        status_t    status;
        logic       locked;
        logic [3:0] attempts;
    } pcl_result_t;

    function automatic logic pin_well_formed(input logic [PIN_WIDTH-1:0] p,
                                             input logic [3:0] len);
        logic ok;
        ok = (len == 4'(PIN_DIGITS)) && (PIN_DIGITS <= PIN_BYTES);
        for (int i = 0; i < PIN_BYTES; i++)
        begin
            if (i < USED_DIGITS)
            begin
                if ((p[8*i +: 8] < DIGIT_ZERO) || (p[8*i +: 8] > DIGIT_NINE))
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pcl_step.sv =====
// Next-state and result logic for one pin checker request.
`default_nettype none

module pcl_step
    import pcl_pkg::*;
(
    input  wire pcl_state_t            cur,
    input  wire logic [3:0]            max_attempts,
    input  wire logic [31:0]           lockout_ms,
    input  wire logic [1:0]            operation,
    input  wire logic [31:0]           now_ms,
    input  wire logic [PIN_WIDTH-1:0]  entered_pin,
    input  wire logic [3:0]            entered_len,
    input  wire logic [PIN_WIDTH-1:0]  new_pin,
    input  wire logic [3:0]            new_len,
    output pcl_state_t                 nxt,
    output pcl_result_t                res
);

    logic        entered_ok;
    logic        entered_match;
    logic        new_ok;
    logic        new_same;
    logic [31:0] elapsed;
    logic        expired;
    logic [3:0]  base_fail;
    logic [3:0]  inc_fail;
    status_t     status;

    assign entered_ok    = pin_well_formed(entered_pin, entered_len);
    assign entered_match = (entered_pin & USED_MASK) == (cur.pin & USED_MASK);
    assign new_ok        = pin_well_formed(new_pin, new_len);
    assign new_same      = (new_pin & USED_MASK) == (cur.pin & USED_MASK);
    assign elapsed       = now_ms - cur.start;
    assign expired       = elapsed >= lockout_ms;
    assign base_fail     = cur.locked ? 4'd0 : cur.fail;
    assign inc_fail      = (base_fail == COUNT_MAX) ? COUNT_MAX : base_fail + 4'd1;

    always_comb
    begin
        nxt    = cur;
        status = ST_OK;
        case (op_t'(operation))
            OP_VALIDATE, OP_CHANGE:
            begin
                if (cur.locked && !expired)
                begin
                    status = ST_LOCKED;
                end
                else
                begin
                    nxt.locked = 1'b0;
                    nxt.fail   = base_fail;
                    if (!entered_ok)
                    begin
                        status = ST_BAD_FORMAT;
                    end
                    else if (entered_match)
                    begin
                        nxt.fail = 4'd0;
                        if (op_t'(operation) == OP_CHANGE)
                        begin
                            if (!new_ok)
                            begin
                                status = ST_NEW_BAD;
                            end
                            else if (new_same)
                            begin
                                status = ST_NEW_SAME;
                            end
                            else
                            begin
                                nxt.pin = new_pin & USED_MASK;
                            end
                        end
                    end
                    else
                    begin
                        status   = ST_WRONG_PIN;
                        nxt.fail = inc_fail;
                        if (inc_fail >= max_attempts)
                        begin
                            nxt.locked = 1'b1;
                            nxt.start  = now_ms;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                nxt.fail   = 4'd0;
                nxt.locked = 1'b0;
            end
            default:
            begin
                status = ST_BAD_FORMAT;
            end
        endcase
        res.accepted = (status == ST_OK);
        res.status   = status;
        res.locked   = nxt.locked;
        res.attempts = nxt.fail;
    end

endmodule

`default_nettype wire

// ===== hdl/pin_check_with_lockout.sv =====
// Top level of the pin checker with attempt lockout.
//
// Usage:
// - Requests enter on in_valid/in_ready with operation, now_ms and the PINs;
//   each request yields exactly one result on out_valid/out_ready.
// - Configuration: pulse cfg_we with cfg_index (0 max_attempts,
//   1 lockout_ms) and cfg_data; write only while no request is in flight.
// - Path: an accepted request waits in the input register, then moves to the
//   result register, where it is held until out_ready takes it.
// - Throughput: one request per cycle while out_ready stays high; the
//   input register and the result register form one stage each around the
//   check logic; the PIN state updates when the request moves to the result.
// - Stall: with out_ready low the held result stays put and one more request
//   is taken into the input register; in_ready then drops.
// - Reset: stored PIN returns to 123456, count and lock clear, lock time is
//   zero, max_attempts is 5 and lockout_ms is 300000.
`default_nettype none

module pin_check_with_lockout
    import pcl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [31:0]          now_ms,
    input  wire logic [PIN_WIDTH-1:0] entered_pin,
    input  wire logic [3:0]           entered_len,
    input  wire logic [PIN_WIDTH-1:0] new_pin,
    input  wire logic [3:0]           new_len,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      accepted,
    output logic [2:0]                status,
    output logic                      locked,
    output logic [3:0]                attempts
);

`include "pin_check_with_lockout_macros.svh"

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [1:0]           s1_op_reg;
    logic [31:0]          s1_now_reg;
    logic [PIN_WIDTH-1:0] s1_entered_pin_reg;
    logic [3:0]           s1_entered_len_reg;
    logic [PIN_WIDTH-1:0] s1_new_pin_reg;
    logic [3:0]           s1_new_len_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    pcl_result_t          res_reg;
    pcl_result_t          res_next;

    pcl_state_t           state_reg;
    pcl_state_t           state_next;

    logic [3:0]           max_attempts_reg;
    logic [31:0]          lockout_ms_reg;

    logic                 in_fire;
    logic                 s1_adv;
    logic                 s1_fire;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    pcl_step u_step (
        .cur          (state_reg),
        .max_attempts (max_attempts_reg),
        .lockout_ms   (lockout_ms_reg),
        .operation    (s1_op_reg),
        .now_ms       (s1_now_reg),
        .entered_pin  (s1_entered_pin_reg),
        .entered_len  (s1_entered_len_reg),
        .new_pin      (s1_new_pin_reg),
        .new_len      (s1_new_len_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg          <= operation;
            s1_now_reg         <= now_ms;
            s1_entered_pin_reg <= entered_pin;
            s1_entered_len_reg <= entered_len;
            s1_new_pin_reg     <= new_pin;
            s1_new_len_reg     <= new_len;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pin    <= RESET_PIN;
            state_reg.fail   <= 4'd0;
            state_reg.locked <= 1'b0;
            state_reg.start  <= 32'd0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= RESET_MAX_ATTEMPTS;
            lockout_ms_reg   <= RESET_LOCKOUT_MS;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[3:0];
                REG_LOCKOUT_MS:   lockout_ms_reg   <= cfg_data;
                default:          lockout_ms_reg   <= lockout_ms_reg;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = res_reg.accepted;
    assign status    = res_reg.status;
    assign locked    = res_reg.locked;
    assign attempts  = res_reg.attempts;

    `PCL_ASSERT(a_lock_has_count, state_reg.locked |-> (state_reg.fail != 4'd0),
        "lock set with zero failure count")
    `PCL_ASSERT(a_state_holds, !s1_fire |=> $stable(state_reg),
        "PIN state changed without a request")
    `PCL_ASSERT(a_result_follows, s1_fire |=> out_valid_reg,
        "request left input stage without a result")
    `PCL_ASSERT(a_lock_time, $rose(state_reg.locked) |-> (state_reg.start == $past(s1_now_reg)),
        "lock start time not taken from locking request")
    `PCL_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_reg |-> in_ready,
        "input stage empty but not ready")

endmodule

`default_nettype wire

// ===== sim/pin_result_checker.sv =====
// Checker for the pin checker: predicts each result from the accepted requests and compares.
`timescale 1ns / 1ps

module pin_result_checker
    import pcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [31:0]          now_ms,
    input  logic [PIN_WIDTH-1:0] entered_pin,
    input  logic [3:0]           entered_len,
    input  logic [PIN_WIDTH-1:0] new_pin,
    input  logic [3:0]           new_len,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 accepted,
    input  logic [2:0]           status,
    input  logic                 locked,
    input  logic [3:0]           attempts,
    output int                   mismatches,
    output int                   outstanding
);

    logic [PIN_WIDTH-1:0] stored_code;
    logic [3:0]           miss_count;
    logic                 lock_active;
    logic [31:0]          lock_stamp;
    logic [3:0]           miss_limit;
    logic [31:0]          hold_ms;

    pcl_result_t expected_results[$];

    function automatic bit code_well_formed(input logic [PIN_WIDTH-1:0] p,
                                            input logic [3:0] len);
        logic [7:0] ch;
        bit         ok;
        ok = (len == 4'(PIN_DIGITS));
        for (int i = 0; i < PIN_DIGITS; i++)
        begin
            ch = (i < PIN_BYTES) ? p[8*i +: 8] : 8'h00;
            if (ch < DIGIT_ZERO || ch > DIGIT_NINE)
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic status_t try_code(input logic [31:0] t,
                                         input logic [PIN_WIDTH-1:0] p,
                                         input logic [3:0] len);
        logic [31:0] since;
        since = t - lock_stamp;
        if (lock_active)
        begin
            if (since >= hold_ms)
            begin
                lock_active = 1'b0;
                miss_count  = '0;
            end
            else
                return ST_LOCKED;
        end
        if (!code_well_formed(p, len))
            return ST_BAD_FORMAT;
        if ((p & USED_MASK) == (stored_code & USED_MASK))
        begin
            miss_count = '0;
            return ST_OK;
        end
        if (miss_count != COUNT_MAX)
            miss_count = miss_count + 4'd1;
        if (miss_count >= miss_limit)
        begin
            lock_active = 1'b1;
            lock_stamp  = t;
        end
        return ST_WRONG_PIN;
    endfunction

    function automatic pcl_result_t predict_pin_result();
        pcl_result_t r;
        status_t     st;
        case (operation)
            OP_VALIDATE:
                st = try_code(now_ms, entered_pin, entered_len);
            OP_CHANGE:
            begin
                st = try_code(now_ms, entered_pin, entered_len);
                if (st == ST_OK)
                begin
                    if (!code_well_formed(new_pin, new_len))
                        st = ST_NEW_BAD;
                    else if ((new_pin & USED_MASK) == (stored_code & USED_MASK))
                        st = ST_NEW_SAME;
                    else
                        stored_code = new_pin & USED_MASK;
                end
            end
            OP_CLEAR:
            begin
                miss_count  = '0;
                lock_active = 1'b0;
                st          = ST_OK;
            end
            default:
                st = ST_BAD_FORMAT;
        endcase
        r.accepted = (st == ST_OK);
        r.status   = st;
        r.locked   = lock_active;
        r.attempts = miss_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pcl_result_t want;
        pcl_result_t got;
        if (!rst_n)
        begin
            stored_code = RESET_PIN;
            miss_count  = '0;
            lock_active = 1'b0;
            lock_stamp  = '0;
            miss_limit  = RESET_MAX_ATTEMPTS;
            hold_ms     = RESET_LOCKOUT_MS;
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ATTEMPTS: miss_limit = cfg_data[3:0];
                    REG_LOCKOUT_MS:   hold_ms    = cfg_data;
                    default:          hold_ms    = hold_ms;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{accepted, status_t'(status), locked, attempts};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: result with no request pending: ",
                                  "accepted=%0d status=%0d locked=%0d attempts=%0d"},
                                 $time, accepted, status, locked, attempts);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected accepted=%0d status=%0d ",
                                      "locked=%0d attempts=%0d, got accepted=%0d ",
                                      "status=%0d locked=%0d attempts=%0d"},
                                     $time, want.accepted, want.status, want.locked,
                                     want.attempts, accepted, status, locked, attempts);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_pin_result());
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the pin checker: clock, reset, request stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import pcl_pkg::*;

    localparam logic [1:0]     OP_SPARE       = 2'd3;
    localparam int             WATCHDOG_LIMIT = 2000;
    localparam int             PHASE_ITEMS    = 166;
    localparam logic [47:0]    PIN_ZEROS      = 48'h303030303030;
    localparam logic [47:0]    PIN_NINES      = 48'h393939393939;
    localparam logic [47:0]    PIN_MIXED      = 48'h353037333831;
    localparam logic [47:0]    PIN_WRONG      = 48'h313233343537;
    localparam logic [47:0]    ALL_ONES       = 48'hFFFFFFFFFFFF;

    typedef struct {
        logic [1:0]           op;
        logic [31:0]          t;
        logic [PIN_WIDTH-1:0] ep;
        logic [3:0]           el;
        logic [PIN_WIDTH-1:0] np;
        logic [3:0]           nl;
    } pin_request_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TIGHT, RX_PERIODIC} rx_mode_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic                 cfg_index   = 1'b0;
    logic [31:0]          cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation   = '0;
    logic [31:0]          now_ms      = '0;
    logic [PIN_WIDTH-1:0] entered_pin = '0;
    logic [3:0]           entered_len = '0;
    logic [PIN_WIDTH-1:0] new_pin     = '0;
    logic [3:0]           new_len     = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 accepted;
    logic [2:0]           status;
    logic                 locked;
    logic [3:0]           attempts;
    int                   mismatches;
    int                   outstanding;

    int          burst_left = 4;
    int          idle_cycles = 0;
    int          stall_left = 0;
    rx_mode_t    stall_mode = RX_OPEN;
    logic [31:0] clock_ms = '0;
    logic [31:0] step_cap = 32'd100001;

    pin_check_with_lockout DUT (.*);

    pin_result_checker u_checker (.*);

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= rx_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= ($urandom_range(0, 1) == 0);
            RX_TIGHT: out_ready <= ($urandom_range(0, 7) == 0);
            default:  out_ready <= (stall_left % 8 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pin_check_with_lockout verification failed");
            $finish;
        end
    end

    function automatic pin_request_t mk(input logic [1:0] op, input logic [31:0] t,
                                        input logic [47:0] ep, input logic [3:0] el,
                                        input logic [47:0] np, input logic [3:0] nl);
        pin_request_t r;
        r.op = op;
        r.t  = t;
        r.ep = ep;
        r.el = el;
        r.np = np;
        r.nl = nl;
        return r;
    endfunction

    function automatic logic [47:0] known_pin();
        case ($urandom_range(0, 3))
            0:       return RESET_PIN;
            1:       return PIN_ZEROS;
            2:       return PIN_NINES;
            default: return PIN_MIXED;
        endcase
    endfunction

    function automatic logic [47:0] digit_pin();
        logic [47:0] p;
        for (int i = 0; i < PIN_BYTES; i++)
            p[8*i +: 8] = DIGIT_ZERO + 8'($urandom_range(0, 9));
        return p;
    endfunction

    function automatic logic [47:0] spoil_pin(input logic [47:0] p);
        logic [47:0] q;
        int          k;
        q = p;
        k = $urandom_range(0, PIN_BYTES - 1);
        case ($urandom_range(0, 2))
            0:       q[8*k +: 8] = DIGIT_ZERO - 8'd1;
            1:       q[8*k +: 8] = DIGIT_NINE + 8'd1;
            default: q[8*k +: 8] = 8'($urandom);
        endcase
        return q;
    endfunction

    function automatic logic [47:0] noise_pin();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic pin_request_t rand_request();
        pin_request_t r;
        int           pick;
        pick = $urandom_range(0, 99);
        r.op = (pick < 55) ? OP_VALIDATE : (pick < 82) ? OP_CHANGE :
               (pick < 94) ? OP_CLEAR : OP_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            clock_ms = clock_ms + $urandom_range(0, step_cap);
        else if (pick < 88)
            clock_ms = clock_ms - 32'd1;
        else if (pick >= 94)
            clock_ms = $urandom;
        r.t  = clock_ms;
        r.el = 4'(PIN_DIGITS);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.ep = known_pin();
        else if (pick < 75)
            r.ep = digit_pin();
        else if (pick < 85)
        begin
            r.ep = known_pin();
            r.el = 4'($urandom_range(0, 15));
        end
        else if (pick < 93)
            r.ep = spoil_pin(known_pin());
        else
        begin
            r.ep = noise_pin();
            r.el = 4'($urandom_range(0, 15));
        end
        r.nl = 4'(PIN_DIGITS);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            r.np = known_pin();
        else if (pick < 80)
        begin
            r.np = known_pin();
            r.nl = 4'($urandom_range(0, 15));
        end
        else if (pick < 90)
            r.np = spoil_pin(known_pin());
        else
        begin
            r.np = noise_pin();
            r.nl = 4'($urandom_range(0, 15));
        end
        return r;
    endfunction

    task automatic issue(input pin_request_t r);
        @(negedge clk);
        in_valid    = 1'b1;
        operation   = r.op;
        now_ms      = r.t;
        entered_pin = r.ep;
        entered_len = r.el;
        new_pin     = r.np;
        new_len     = r.nl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_policy(input logic [3:0] limit, input logic [31:0] hold);
        drain();
        write_reg(REG_MAX_ATTEMPTS, 32'(limit));
        write_reg(REG_LOCKOUT_MS, hold);
        if (hold == 0)
            step_cap = 32'd1000;
        else if (hold > 32'h30000000)
            step_cap = 32'h30000000;
        else
            step_cap = hold / 3 + 1;
        clock_ms = $urandom;
    endtask

    task automatic play_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                drain();
            issue(rand_request());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(mk(OP_VALIDATE, 32'd0, RESET_PIN, 4'd6, '0, '0));
        issue(mk(OP_VALIDATE, 32'd1, RESET_PIN, 4'd5, '0, '0));
        issue(mk(OP_VALIDATE, 32'd2, '0, 4'd0, '0, '0));
        issue(mk(OP_VALIDATE, 32'd3, ALL_ONES, 4'd15, ALL_ONES, 4'd15));
        issue(mk(OP_VALIDATE, 32'd4, 48'h2F3233343536, 4'd6, '0, '0));
        issue(mk(OP_VALIDATE, 32'd5, 48'h31323334353A, 4'd6, '0, '0));
        for (int n = 0; n < 5; n++)
            issue(mk(OP_VALIDATE, 32'd1000 + 32'(n), PIN_WRONG, 4'd6, '0, '0));
        issue(mk(OP_VALIDATE, 32'd301003, RESET_PIN, 4'd6, '0, '0));
        issue(mk(OP_VALIDATE, 32'd301004, RESET_PIN, 4'd6, '0, '0));
        issue(mk(OP_CHANGE, 32'd301005, PIN_WRONG, 4'd6, PIN_ZEROS, 4'd6));
        issue(mk(OP_CHANGE, 32'd301006, RESET_PIN, 4'd6, PIN_ZEROS, 4'd5));
        issue(mk(OP_CHANGE, 32'd301007, RESET_PIN, 4'd6, RESET_PIN, 4'd6));
        issue(mk(OP_CHANGE, 32'd301008, RESET_PIN, 4'd6, PIN_ZEROS, 4'd6));
        issue(mk(OP_VALIDATE, 32'd301009, PIN_ZEROS, 4'd6, '0, '0));
        issue(mk(OP_CHANGE, 32'd301010, PIN_ZEROS, 4'd6, PIN_NINES, 4'd6));
        issue(mk(OP_VALIDATE, 32'd301011, PIN_ZEROS, 4'd6, '0, '0));
        issue(mk(OP_CLEAR, 32'd301012, ALL_ONES, 4'd15, ALL_ONES, 4'd15));
        issue(mk(OP_SPARE, 32'hFFFFFFFF, ALL_ONES, 4'd15, ALL_ONES, 4'd15));
        issue(mk(OP_CHANGE, 32'hFFFFFFFF, PIN_NINES, 4'd6, '0, 4'd0));
        issue(mk(OP_CHANGE, 32'd0, ALL_ONES, 4'd15, PIN_MIXED, 4'd6));
        clock_ms = 32'd301100;

        play_random(PHASE_ITEMS);
        set_policy(4'd1, 32'd0);
        play_random(PHASE_ITEMS);
        set_policy(4'd15, 32'hFFFFFFFF);
        play_random(PHASE_ITEMS);
        set_policy(4'd0, 32'd100);
        play_random(PHASE_ITEMS);
        set_policy(4'd3, 32'd5000);
        play_random(PHASE_ITEMS);
        set_policy(4'd15, 32'd0);
        play_random(PHASE_ITEMS);
        set_policy(4'd7, 32'd1);
        play_random(PHASE_ITEMS);
        set_policy(4'($urandom_range(1, 15)), 32'($urandom_range(1, 100000)));
        play_random(PHASE_ITEMS);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("pin_check_with_lockout verification clean");
        else
            $display("pin_check_with_lockout verification failed");
        $finish;
    end

endmodule
